FILE: design/gbw_pkg.sv
// Package for the glyph bitmap pixel writer.
// Holds the opcode, format and register index codes, the configuration struct and the
// RGB565 conversion. No dependencies.
package gbw_pkg;

  localparam int OFFSET_BITS = 26;
  localparam int DATA_BITS   = 32;
  localparam int DIM_BITS    = 13;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    FMT_8    = 2'd0,
    FMT_16   = 2'd1,
    FMT_32   = 2'd2,
    FMT_NONE = 2'd3
  } pix_fmt_e;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_PIXEL_FORMAT  = 2'd2,
    CFG_FONT_COLOR    = 2'd3
  } cfg_idx_e;

  localparam logic STATUS_WRITE  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [7:0] DEPTH_MONO = 8'd1;
  localparam logic [7:0] DEPTH_BYTE = 8'd8;

  localparam logic [DIM_BITS-1:0]  RST_SCREEN_WIDTH  = 13'd480;
  localparam logic [DIM_BITS-1:0]  RST_SCREEN_HEIGHT = 13'd272;
  localparam pix_fmt_e             RST_PIXEL_FORMAT  = FMT_16;
  localparam logic [DATA_BITS-1:0] RST_FONT_COLOR    = 32'd0;

  typedef struct packed {
    logic [DIM_BITS-1:0]  screen_width;
    logic [DIM_BITS-1:0]  screen_height;
    pix_fmt_e             pixel_format;
    logic [DATA_BITS-1:0] font_color;
  } cfg_t;

  function automatic logic [DATA_BITS-1:0] rgb565(input logic [DATA_BITS-1:0] c);
    rgb565 = {16'd0, c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

FILE: design/gbw_if.sv
// Channel interfaces of the glyph bitmap pixel writer: input items, pixel results and
// configuration writes. Valid/ready handshake on each. No dependencies.
interface gbw_in_if #(
  parameter int COORD_BITS = 12,
  parameter int PITCH_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COORD_BITS-1:0] glyph_left;
  logic [COORD_BITS-1:0] glyph_top;
  logic [COORD_BITS-1:0] glyph_right;
  logic [COORD_BITS-1:0] glyph_bottom;
  logic [7:0]            source_depth;
  logic [PITCH_BITS-1:0] row_pitch;
  logic [7:0]            data_byte;

  modport source (
    output valid, opcode, glyph_left, glyph_top, glyph_right, glyph_bottom,
           source_depth, row_pitch, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, glyph_left, glyph_top, glyph_right, glyph_bottom,
           source_depth, row_pitch, data_byte,
    output ready
  );
endinterface

interface gbw_out_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [25:0]           byte_offset;
  logic [31:0]           write_data;
  logic [1:0]            write_size;
  logic                  last;

  modport source (
    output valid, status, pixel_x, pixel_y, byte_offset, write_data, write_size, last,
    input  ready
  );
  modport sink (
    input  valid, status, pixel_x, pixel_y, byte_offset, write_data, write_size, last,
    output ready
  );
endinterface

interface gbw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: design/gbw_front.sv
// Front end: accepts headers and source bytes, tracks the glyph walk and emits one job
// per rejected header or per byte with set pixels in the glyph. Uses gbw_pkg, gbw_in_if.
module gbw_front #(
  parameter int COORD_BITS = 12,
  parameter int PITCH_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  gbw_in_if.sink                  in_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output logic [2*COORD_BITS+8:0] job_o
);

  localparam int CW = COORD_BITS + 1;

  logic                  active_q, active_d;
  logic                  mono_q, mono_d;
  logic [COORD_BITS-1:0] left_q, left_d;
  logic [COORD_BITS-1:0] right_q, right_d;
  logic [COORD_BITS-1:0] bottom_q, bottom_d;
  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [PITCH_BITS-1:0] bir_q, bir_d;
  logic [PITCH_BITS-1:0] pitch_q, pitch_d;

  logic                  acc;
  logic                  is_hdr;
  logic                  depth_ok;
  logic [7:0]            mask;
  logic [CW-1:0]         col_step;
  logic [COORD_BITS-1:0] col_adv;
  logic [COORD_BITS-1:0] row_inc;
  logic [PITCH_BITS-1:0] bir_inc;
  logic [COORD_BITS-1:0] hdr_start;
  logic [COORD_BITS-1:0] cur_start;

  assign in_i.ready = job_ready_i;
  assign acc        = in_i.valid && in_i.ready;
  assign is_hdr     = (in_i.opcode == gbw_pkg::OP_HEADER);
  assign depth_ok   = (in_i.source_depth == gbw_pkg::DEPTH_MONO) ||
                      (in_i.source_depth == gbw_pkg::DEPTH_BYTE);

  always_comb begin
    logic [CW-1:0] colx;
    for (int i = 0; i < 8; i++) begin
      colx = {1'b0, col_q} + CW'(i);
      if (mono_q) begin
        mask[i] = in_i.data_byte[7-i] && (colx < {1'b0, right_q});
      end else begin
        mask[i] = (i == 0) && (in_i.data_byte != 8'd0) && (colx < {1'b0, right_q});
      end
    end
  end

  assign col_step  = {1'b0, col_q} + (mono_q ? CW'(8) : CW'(1));
  assign col_adv   = (col_step < {1'b0, right_q}) ? col_step[COORD_BITS-1:0] : right_q;
  assign row_inc   = row_q + 1'b1;
  assign bir_inc   = bir_q + 1'b1;
  assign hdr_start = (in_i.glyph_left < in_i.glyph_right) ? in_i.glyph_left
                                                          : in_i.glyph_right;
  assign cur_start = (left_q < right_q) ? left_q : right_q;

  always_comb begin
    active_d = active_q;
    mono_d   = mono_q;
    left_d   = left_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    col_d    = col_q;
    row_d    = row_q;
    bir_d    = bir_q;
    pitch_d  = pitch_q;
    if (acc) begin
      if (is_hdr) begin
        if (!depth_ok) begin
          active_d = 1'b0;
        end else begin
          mono_d   = (in_i.source_depth == gbw_pkg::DEPTH_MONO);
          left_d   = in_i.glyph_left;
          right_d  = in_i.glyph_right;
          bottom_d = in_i.glyph_bottom;
          pitch_d  = in_i.row_pitch;
          col_d    = hdr_start;
          row_d    = in_i.glyph_top;
          bir_d    = '0;
          active_d = (in_i.glyph_top < in_i.glyph_bottom) && (in_i.row_pitch != '0);
        end
      end else if (active_q) begin
        col_d = col_adv;
        bir_d = bir_inc;
        if (bir_inc >= pitch_q) begin
          bir_d = '0;
          col_d = cur_start;
          row_d = row_inc;
          if ((row_inc >= bottom_q) || (row_inc == '0)) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mono_q   <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      bir_q    <= '0;
      pitch_q  <= '0;
    end else begin
      active_q <= active_d;
      mono_q   <= mono_d;
      left_q   <= left_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
      col_q    <= col_d;
      row_q    <= row_d;
      bir_q    <= bir_d;
      pitch_q  <= pitch_d;
    end
  end

  // job: reject flag, row, first column, column mask
  assign job_valid_o = acc && (is_hdr ? !depth_ok : (active_q && (mask != 8'd0)));
  assign job_o       = {is_hdr, row_q, col_q, mask};

endmodule

FILE: design/gbw_fifo.sv
// Small register queue between the front and back ends.
// Generic width and depth; no dependencies.
module gbw_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (cnt_q != NW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/gbw_back.sv
// Back end: clips each job to the screen, computes the row base, then issues one pixel
// write per cycle into the output register when not stalled. Uses gbw_pkg, gbw_out_if.
module gbw_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gbw_pkg::cfg_t           cfg_i,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  logic [2*COORD_BITS+8:0] job_i,
  gbw_out_if.source               out_o
);

  localparam int PRW  = COORD_BITS + gbw_pkg::DIM_BITS;
  localparam int CW   = COORD_BITS + 1;
  localparam int CMPW = ((CW > gbw_pkg::DIM_BITS) ? CW : gbw_pkg::DIM_BITS) + 1;
  localparam int OW   = (COORD_BITS + 16 > gbw_pkg::OFFSET_BITS) ? COORD_BITS + 16
                                                                 : gbw_pkg::OFFSET_BITS;

  logic                  head_rej;
  logic [COORD_BITS-1:0] head_y;
  logic [COORD_BITS-1:0] head_col;
  logic [7:0]            head_mask;
  logic [7:0]            head_wmask;

  logic                  cur_valid_q, cur_valid_d;
  logic                  cur_rej_q, cur_rej_d;
  logic [7:0]            cur_mask_q, cur_mask_d;
  logic [COORD_BITS-1:0] cur_col_q, cur_col_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic [PRW-1:0]        cur_base_q, cur_base_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_status_q, out_status_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d;
  logic [COORD_BITS-1:0] out_y_q, out_y_d;
  logic [25:0]           out_off_q, out_off_d;
  logic [31:0]           out_data_q, out_data_d;
  logic [1:0]            out_size_q, out_size_d;
  logic                  out_last_q, out_last_d;

  logic                  emit_ok;
  logic                  step;
  logic                  cur_done;
  logic                  cur_free;
  logic                  load;
  logic [2:0]            sel;
  logic [7:0]            mask_rest;
  logic [CW-1:0]         pix_x;
  logic [OW-1:0]         lin;
  logic [OW-1:0]         off;
  logic [31:0]           pix_data;

  assign {head_rej, head_y, head_col, head_mask} = job_i;

  always_comb begin
    logic [CMPW-1:0] colx;
    for (int i = 0; i < 8; i++) begin
      colx = CMPW'(head_col) + CMPW'(i);
      head_wmask[i] = head_mask[i] && (colx < CMPW'(cfg_i.screen_width)) &&
                      (CMPW'(head_y) < CMPW'(cfg_i.screen_height)) &&
                      (cfg_i.pixel_format != gbw_pkg::FMT_NONE);
    end
  end

  always_comb begin
    sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign mask_rest = cur_mask_q & (cur_mask_q - 8'd1);
  assign emit_ok   = !out_valid_q || out_o.ready;
  assign step      = cur_valid_q && emit_ok;
  assign cur_done  = cur_rej_q || (mask_rest == 8'd0);
  assign cur_free  = !cur_valid_q || (step && cur_done);
  assign job_ready_o = cur_free;
  assign load      = job_valid_i && cur_free;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_rej_d   = cur_rej_q;
    cur_mask_d  = cur_mask_q;
    cur_col_d   = cur_col_q;
    cur_y_d     = cur_y_q;
    cur_base_d  = cur_base_q;
    if (step) begin
      cur_mask_d = mask_rest;
      if (cur_done) begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_valid_d = head_rej || (head_wmask != 8'd0);
      cur_rej_d   = head_rej;
      cur_mask_d  = head_wmask;
      cur_col_d   = head_col;
      cur_y_d     = head_y;
      cur_base_d  = PRW'(head_y) * PRW'(cfg_i.screen_width);
    end
  end

  assign pix_x = CW'(cur_col_q) + CW'(sel);
  assign lin   = OW'(cur_base_q) + OW'(pix_x);

  always_comb begin
    unique case (cfg_i.pixel_format)
      gbw_pkg::FMT_8: begin
        off      = lin;
        pix_data = {24'd0, cfg_i.font_color[7:0]};
      end
      gbw_pkg::FMT_16: begin
        off      = lin << 1;
        pix_data = gbw_pkg::rgb565(cfg_i.font_color);
      end
      gbw_pkg::FMT_32: begin
        off      = lin << 2;
        pix_data = cfg_i.font_color;
      end
      default: begin
        off      = '0;
        pix_data = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_off_d    = out_off_q;
    out_data_d   = out_data_q;
    out_size_d   = out_size_q;
    out_last_d   = out_last_q;
    if (step) begin
      out_valid_d = 1'b1;
      if (cur_rej_q) begin
        out_status_d = gbw_pkg::STATUS_REJECT;
        out_x_d      = '0;
        out_y_d      = '0;
        out_off_d    = '0;
        out_data_d   = '0;
        out_size_d   = '0;
        out_last_d   = 1'b1;
      end else begin
        out_status_d = gbw_pkg::STATUS_WRITE;
        out_x_d      = pix_x[COORD_BITS-1:0];
        out_y_d      = cur_y_q;
        out_off_d    = off[25:0];
        out_data_d   = pix_data;
        out_size_d   = cfg_i.pixel_format;
        out_last_d   = (mask_rest == 8'd0);
      end
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_rej_q    <= cur_rej_d;
    cur_mask_q   <= cur_mask_d;
    cur_col_q    <= cur_col_d;
    cur_y_q      <= cur_y_d;
    cur_base_q   <= cur_base_d;
    out_status_q <= out_status_d;
    out_x_q      <= out_x_d;
    out_y_q      <= out_y_d;
    out_off_q    <= out_off_d;
    out_data_q   <= out_data_d;
    out_size_q   <= out_size_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.pixel_x     = out_x_q;
  assign out_o.pixel_y     = out_y_q;
  assign out_o.byte_offset = out_off_q;
  assign out_o.write_data  = out_data_q;
  assign out_o.write_size  = out_size_q;
  assign out_o.last        = out_last_q;

`ifndef SYNTH
  a_cur_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_rej_q || (cur_mask_q != 8'd0)))
    else $error("pixel job held with an empty mask");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == gbw_pkg::STATUS_REJECT)) |->
      (out_last_q && (out_off_q == '0) && (out_data_q == '0)))
    else $error("reject result with stray fields");

  a_pixel_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == gbw_pkg::STATUS_WRITE)) |->
      ((CMPW'(out_x_q) < CMPW'(cfg_i.screen_width)) &&
       (CMPW'(out_y_q) < CMPW'(cfg_i.screen_height))))
    else $error("pixel write outside the screen");
`endif

endmodule

FILE: design/glyph_bitmap_pixel_writer.sv
// Top level of the glyph bitmap pixel writer: configuration registers, front end, job
// queue and back end. Uses gbw_pkg, gbw_if, gbw_front, gbw_fifo, gbw_back.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    opcode, glyph rectangle, source_depth, row_pitch, data_byte
//   cfg_i    in   valid/ready    index, wdata (always ready)
//   out_o    out  valid/ready    status, pixel_x/y, byte_offset, write_data/size, last
//
// An input item is taken whenever the two-entry job queue has room. Pixel writes leave
// at one per cycle, unless out_o stalls, through the single output register, so a 1-bpp
// byte makes up to eight writes; its job goes through the queue and the job register.
// The row base multiply fills the job register while the previous job drains, no bubble.
// Reset clears the glyph state and queue and loads the register defaults.
// Output stalls back up through the queue to in_i.ready.
module glyph_bitmap_pixel_writer #(
  parameter int COORD_BITS = 12,
  parameter int PITCH_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbw_in_if.sink     in_i,
  gbw_cfg_if.sink    cfg_i,
  gbw_out_if.source  out_o
);

  localparam int JOB_BITS = 2 * COORD_BITS + 9;

  gbw_pkg::cfg_t cfg_q, cfg_d;

  logic                front_valid;
  logic                front_ready;
  logic [JOB_BITS-1:0] front_job;
  logic                back_valid;
  logic                back_ready;
  logic [JOB_BITS-1:0] back_job;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (gbw_pkg::cfg_idx_e'(cfg_i.index))
        gbw_pkg::CFG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_i.wdata[gbw_pkg::DIM_BITS-1:0];
        gbw_pkg::CFG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_i.wdata[gbw_pkg::DIM_BITS-1:0];
        gbw_pkg::CFG_PIXEL_FORMAT:  cfg_d.pixel_format  = gbw_pkg::pix_fmt_e'(cfg_i.wdata[1:0]);
        gbw_pkg::CFG_FONT_COLOR:    cfg_d.font_color    = cfg_i.wdata;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= gbw_pkg::RST_SCREEN_WIDTH;
      cfg_q.screen_height <= gbw_pkg::RST_SCREEN_HEIGHT;
      cfg_q.pixel_format  <= gbw_pkg::RST_PIXEL_FORMAT;
      cfg_q.font_color    <= gbw_pkg::RST_FONT_COLOR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gbw_front #(
    .COORD_BITS (COORD_BITS),
    .PITCH_BITS (PITCH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  gbw_fifo #(
    .WIDTH (JOB_BITS),
    .DEPTH (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_job)
  );

  gbw_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_o       (out_o)
  );

endmodule
